FILE: rtl/group_positions_by_key_macros.svh
// Assertion macros used by the checker file.
`ifndef GROUP_POSITIONS_BY_KEY_MACROS_SVH
`define GROUP_POSITIONS_BY_KEY_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GPK_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define GPK_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/gpk_pkg.sv
`default_nettype none

package gpk_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_COUNT = 256;
  localparam int QDEPTH    = 4;

  localparam int KEY_W  = 8;
  localparam int POS_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int KA_W   = $clog2(KEY_COUNT);
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [KEY_W-1:0] MAX_KEY_RST = 8'hFF;

  typedef logic [KA_W-1:0] hist_addr_t;

  // One classified item between front and back.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             keep;
    logic             last;
  } q_entry_t;

  // One result as held in the result buffer and the output register.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rank;
    logic             gend;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/gpk_front.sv
`default_nettype none

module gpk_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gpk_pkg::KEY_W-1:0] key_value_i,
  input  logic                      last_item_i,
  input  logic                      cfg_we_i,
  input  logic [gpk_pkg::KEY_W-1:0] cfg_wdata_i,
  input  logic                      full_i,
  output logic                      push_o,
  output gpk_pkg::q_entry_t         push_data_o
);

  logic [gpk_pkg::KEY_W-1:0] max_key_q;
  logic [gpk_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      keep;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Drop keys out of range and keys beyond a full set.
  assign keep = (key_value_i <= max_key_q)
             && (32'(key_value_i) < gpk_pkg::KEY_COUNT)
             && (cnt_q < gpk_pkg::CNT_W'(gpk_pkg::MAX_ITEMS));

  assign push_data_o = '{key: key_value_i, keep: keep, last: last_item_i};

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (last_item_i) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_key_q <= gpk_pkg::MAX_KEY_RST;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_key_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gpk_fifo.sv
`default_nettype none

module gpk_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gpk_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output gpk_pkg::q_entry_t pop_data_o,
  output logic              empty_o
);

  gpk_pkg::q_entry_t          mem_q [gpk_pkg::QDEPTH];
  logic [gpk_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [gpk_pkg::QCNT_W-1:0] cnt_q;
  logic                       do_push, do_pop;

  assign full_o     = (cnt_q == gpk_pkg::QCNT_W'(gpk_pkg::QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == gpk_pkg::QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == gpk_pkg::QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gpk_back.sv
`default_nettype none

module gpk_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  gpk_pkg::q_entry_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gpk_pkg::res_t     res_o,
  output logic              run_end_o
);

  typedef enum logic [5:0] {
    ST_LOAD    = 6'b000001,
    ST_DRAIN   = 6'b000010,
    ST_PREFIX  = 6'b000100,
    ST_SCATTER = 6'b001000,
    ST_SC_WAIT = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_OFFSET = 2'd1,
    OP_PLACE  = 2'd2
  } op_e;

  // Histogram word: count in lim while loading; next slot, rank and group limit
  // after the prefix pass.
  typedef struct packed {
    logic [gpk_pkg::POS_W-1:0] cur;
    logic [gpk_pkg::POS_W-1:0] rank;
    logic [gpk_pkg::CNT_W-1:0] lim;
  } hist_entry_t;

  state_e state_q, state_d;

  logic [gpk_pkg::CNT_W-1:0] n_q, n_d;
  logic [gpk_pkg::CNT_W-1:0] i_q, i_d;
  logic [gpk_pkg::CNT_W-1:0] e_q, e_d;
  logic [gpk_pkg::CNT_W-1:0] run_sum_q, run_sum_d;
  gpk_pkg::hist_addr_t       k_q, k_d;

  // Key store
  logic [gpk_pkg::KEY_W-1:0] ks_mem [gpk_pkg::MAX_ITEMS];
  logic [gpk_pkg::KEY_W-1:0] ks_rd_q;
  logic                      ks_we, ks_re;

  // Histogram memory with per-entry valid bits
  hist_entry_t                   hist_mem [gpk_pkg::KEY_COUNT];
  logic [gpk_pkg::KEY_COUNT-1:0] hist_vld_q;
  hist_entry_t                   hist_rd_q;
  logic                          hist_rd_vld_q;
  logic                          hist_re, hist_we, hist_clr;
  gpk_pkg::hist_addr_t           hist_raddr;
  hist_entry_t                   hist_wdata;

  // One-deep write forwarding for read-modify-write
  logic                fwd_vld_q;
  gpk_pkg::hist_addr_t fwd_addr_q;
  hist_entry_t         fwd_data_q;
  hist_entry_t         eff;

  // Scatter stage 1 and the histogram consumer stage
  logic                      s1_vld_q, s1_vld_d;
  logic [gpk_pkg::POS_W-1:0] s1_pos_q;
  logic                      c_vld_q, c_vld_d;
  op_e                       c_op_q, c_op_d;
  gpk_pkg::hist_addr_t       c_addr_q;
  logic [gpk_pkg::KEY_W-1:0] c_key_q, c_key_d;
  logic [gpk_pkg::POS_W-1:0] c_pos_q, c_pos_d;

  // Result buffer and output register
  gpk_pkg::res_t             res_mem [gpk_pkg::MAX_ITEMS];
  logic                      res_we;
  logic [gpk_pkg::POS_W-1:0] res_waddr;
  gpk_pkg::res_t             res_wdata;
  gpk_pkg::res_t             out_q;
  logic                      out_vld_q;
  logic                      run_end_q;
  logic                      out_load;

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign run_end_o   = run_end_q;

  assign eff = (fwd_vld_q && (fwd_addr_q == c_addr_q)) ? fwd_data_q :
               (hist_rd_vld_q ? hist_rd_q : '0);

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    i_d        = i_q;
    e_d        = e_q;
    k_d        = k_q;
    run_sum_d  = run_sum_q;
    q_pop_o    = 1'b0;
    ks_we      = 1'b0;
    ks_re      = 1'b0;
    hist_re    = 1'b0;
    hist_raddr = '0;
    hist_clr   = 1'b0;
    c_vld_d    = 1'b0;
    c_op_d     = OP_COUNT;
    c_key_d    = c_key_q;
    c_pos_d    = c_pos_q;
    s1_vld_d   = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.keep) begin
            ks_we      = 1'b1;
            n_d        = n_q + 1'b1;
            hist_re    = 1'b1;
            hist_raddr = gpk_pkg::hist_addr_t'(q_data_i.key);
            c_vld_d    = 1'b1;
            c_op_d     = OP_COUNT;
            c_key_d    = q_data_i.key;
          end
          if (q_data_i.last) begin
            if (n_d == '0) begin
              hist_clr = 1'b1;
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        state_d   = ST_PREFIX;
        k_d       = '0;
        run_sum_d = '0;
      end
      ST_PREFIX: begin
        hist_re    = 1'b1;
        hist_raddr = k_q;
        c_vld_d    = 1'b1;
        c_op_d     = OP_OFFSET;
        k_d        = k_q + 1'b1;
        if (k_q == gpk_pkg::hist_addr_t'(gpk_pkg::KEY_COUNT - 1)) begin
          state_d = ST_SCATTER;
          i_d     = '0;
        end
      end
      ST_SCATTER: begin
        ks_re    = 1'b1;
        s1_vld_d = 1'b1;
        i_d      = i_q + 1'b1;
        if (i_q == n_q - 1'b1) begin
          state_d = ST_SC_WAIT;
        end
      end
      ST_SC_WAIT: begin
        if (!s1_vld_q && !c_vld_q) begin
          state_d = ST_EMIT;
          e_d     = '0;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          e_d      = e_q + 1'b1;
          if (e_q == n_q - 1'b1) begin
            state_d  = ST_LOAD;
            n_d      = '0;
            hist_clr = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // Scatter stage 1: stored key known, look up its slot.
    if (s1_vld_q) begin
      hist_re    = 1'b1;
      hist_raddr = gpk_pkg::hist_addr_t'(ks_rd_q);
      c_vld_d    = 1'b1;
      c_op_d     = OP_PLACE;
      c_key_d    = ks_rd_q;
      c_pos_d    = s1_pos_q;
    end

    // Histogram consumer: modify and write back.
    hist_we   = 1'b0;
    hist_wdata = eff;
    res_we    = 1'b0;
    res_waddr = eff.cur;
    res_wdata = '{key: c_key_q, pos: c_pos_q, rank: eff.rank,
                  gend: ((gpk_pkg::CNT_W'(eff.cur) + gpk_pkg::CNT_W'(1)) == eff.lim)};
    if (c_vld_q) begin
      unique case (c_op_q)
        OP_COUNT: begin
          hist_we    = 1'b1;
          hist_wdata = '{cur: '0, rank: '0, lim: eff.lim + 1'b1};
        end
        OP_OFFSET: begin
          if (eff.lim != '0) begin
            hist_we    = 1'b1;
            hist_wdata = '{cur: run_sum_q[gpk_pkg::POS_W-1:0], rank: '0,
                           lim: run_sum_q + eff.lim};
            run_sum_d  = run_sum_q + eff.lim;
          end
        end
        OP_PLACE: begin
          hist_we    = 1'b1;
          hist_wdata = '{cur: eff.cur + 1'b1, rank: eff.rank + 1'b1, lim: eff.lim};
          res_we     = 1'b1;
        end
        default: begin
          hist_we = 1'b0;
        end
      endcase
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (ks_we) begin
      ks_mem[n_q[gpk_pkg::POS_W-1:0]] <= q_data_i.key;
    end
    if (ks_re) begin
      ks_rd_q <= ks_mem[i_q[gpk_pkg::POS_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[c_addr_q] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_q     <= hist_mem[hist_raddr];
      hist_rd_vld_q <= hist_vld_q[hist_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (out_load) begin
      out_q     <= res_mem[e_q[gpk_pkg::POS_W-1:0]];
      run_end_q <= (e_q == n_q - 1'b1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    c_op_q     <= c_op_d;
    c_addr_q   <= hist_raddr;
    c_key_q    <= c_key_d;
    c_pos_q    <= c_pos_d;
    s1_pos_q   <= i_q[gpk_pkg::POS_W-1:0];
    fwd_addr_q <= c_addr_q;
    fwd_data_q <= hist_wdata;
    run_sum_q  <= run_sum_d;
    k_q        <= k_d;
    i_q        <= i_d;
    e_q        <= e_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      n_q        <= '0;
      hist_vld_q <= '0;
      c_vld_q    <= 1'b0;
      s1_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      c_vld_q   <= c_vld_d;
      s1_vld_q  <= s1_vld_d;
      fwd_vld_q <= hist_we;
      out_vld_q <= out_load || (out_vld_q && !out_ready_i);
      if (hist_clr) begin
        hist_vld_q <= '0;
      end else if (hist_we) begin
        hist_vld_q[c_addr_q] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/group_positions_by_key.sv
// Loading: one key per cycle while the queue is not full, queue of 4.
// After the last item: a drain step, a prefix pass over every key and a scatter
// pass, then one result per cycle while out_ready_i is high; the back end takes
// no new items from the queue until the whole set has been emitted.
// Reset (async, active low) empties the set, clears histogram valid bits and
// sets max_key to 255; stored keys and results are not cleared.
`default_nettype none

module group_positions_by_key (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] key_value_i,
  input  logic       last_item_i,
  // configuration: max_key
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // results
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] group_key_o,
  output logic [5:0] position_o,
  output logic [5:0] rank_in_group_o,
  output logic       group_end_o,
  output logic       run_end_o
);

  // Front: holds max_key and the fill count of the current set, classifies
  // each item as kept or dropped and pushes it into the queue.
  logic              q_full, q_empty, q_push, q_pop;
  gpk_pkg::q_entry_t q_wdata, q_rdata;
  gpk_pkg::res_t     res;

  gpk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_value_i (key_value_i),
    .last_item_i (last_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  // Queue: lets the front keep taking items while the back end sorts and
  // emits; the front stalls only when the queue is full.
  gpk_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  // Back end: counts keys into the histogram while loading, then turns the
  // counts into start slots (prefix pass), scatters each position into its
  // slot in a result buffer, and streams the buffer out in order.
  gpk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .run_end_o   (run_end_o)
  );

  // Split the result word into its fields.
  assign group_key_o     = res.key;
  assign position_o      = 6'(res.pos);
  assign rank_in_group_o = 6'(res.rank);
  assign group_end_o     = res.gend;

endmodule

`default_nettype wire

FILE: rtl/gpk_checker.sv
`default_nettype none
`include "group_positions_by_key_macros.svh"

module gpk_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] group_key_o,
  input logic [5:0] position_o,
  input logic [5:0] rank_in_group_o,
  input logic       group_end_o,
  input logic       run_end_o
);

  `GPK_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o,
                   "result dropped while stalled")
  `GPK_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
                   $stable({group_key_o, position_o, rank_in_group_o, group_end_o, run_end_o}),
                   "stalled result changed")
  `GPK_ASSERT_NOW(a_run_end_gend, out_valid_o && run_end_o, group_end_o,
                  "run end without group end")
  `GPK_ASSERT_NOW(a_rank_le_pos, out_valid_o, rank_in_group_o <= position_o,
                  "rank beyond position")

endmodule

bind group_positions_by_key gpk_checker u_gpk_checker (.*);

`default_nettype wire
